// ----- rtl/core/lzfg_pkg.sv -----
// ----------------------------------------------------------------------------
// lzfg_pkg
// Shared types and constants for the LZSS flag-group decoder.
// ----------------------------------------------------------------------------
package lzfg_pkg;

  localparam int BYTE_W     = 8;
  localparam int HIST_DEPTH = 256;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int LANES      = 4;
  localparam int LANE_IW    = $clog2(LANES);
  localparam int COUNT_W    = 3;
  localparam int STATUS_W   = 2;

  // Input operation codes
  typedef enum logic {
    OP_DATA = 1'b0,
    OP_END  = 1'b1
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DATA  = 2'd0,
    ST_END   = 2'd1,
    ST_TRUNC = 2'd2
  } status_t;

  typedef logic [LANES-1:0][BYTE_W-1:0] lanes_t;

  // History port request from the sequencer
  typedef struct packed {
    logic               we;
    logic [HIST_AW-1:0] waddr;
    logic [BYTE_W-1:0]  wdata;
    logic               re;
    logic [HIST_AW-1:0] raddr;
  } hist_req_t;

endpackage

// ----- rtl/core/lzfg_in_if.sv -----
// ----------------------------------------------------------------------------
// lzfg_in_if
// Compressed byte channel: valid/ready handshake with operation and data.
// ----------------------------------------------------------------------------
interface lzfg_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

// ----- rtl/core/lzfg_out_if.sv -----
// ----------------------------------------------------------------------------
// lzfg_out_if
// Decoded result channel: up to four bytes, count, run marker and status.
// ----------------------------------------------------------------------------
interface lzfg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte0;
  logic [7:0] out_byte1;
  logic [7:0] out_byte2;
  logic [7:0] out_byte3;
  logic [2:0] out_count;
  logic       last_of_run;
  logic [1:0] status;

  modport source (output valid, output out_byte0, output out_byte1, output out_byte2,
                  output out_byte3, output out_count, output last_of_run,
                  output status, input ready);
  modport sink   (input valid, input out_byte0, input out_byte1, input out_byte2,
                  input out_byte3, input out_count, input last_of_run,
                  input status, output ready);
endinterface

// ----- rtl/core/lzfg_top.sv -----
// ----------------------------------------------------------------------------
// lzss_flag_group_decoder_top
// LZSS decoder with a 256-byte history, one compressed byte per transaction.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_ch   | in  | operation, data_byte
//  out_ch  | out | out_byte0..3, out_count, last_of_run, status
//
//  Control, offset, literal and end transactions do not hold input once accepted.
//  A back reference holds input after its length byte until all its bytes are
//  copied: every copied byte is one history read and one history write.
//  A held result blocks every input transaction; during a copy it stalls
//  only the history write that would replace it.
//  Reset clears the parser; the history is not cleared.
// ----------------------------------------------------------------------------
module lzss_flag_group_decoder_top
  import lzfg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  lzfg_in_if.sink    in_ch,
  lzfg_out_if.source out_ch
);

  hist_req_t         hist_req;
  logic [BYTE_W-1:0] hist_rdata;

  lzfg_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .hist_req   (hist_req),
    .hist_rdata (hist_rdata)
  );

  lzfg_history u_history (
    .clk   (clk),
    .req   (hist_req),
    .rdata (hist_rdata)
  );

  // End results carry no bytes and close the run
  a_end_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_DATA |-> out_ch.out_count == '0 && out_ch.last_of_run)
    else $error("end result carries data");

  // Data results carry one to four bytes
  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == ST_DATA |->
      out_ch.out_count != '0 && out_ch.out_count <= COUNT_W'(LANES))
    else $error("bad data result count");

  // No history write and read in the same cycle
  a_hist_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(hist_req.we && hist_req.re))
    else $error("history read and write collide");

endmodule

// ----- rtl/core/lzfg_history.sv -----
// ----------------------------------------------------------------------------
// lzfg_history
// 256-byte history window: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lzfg_history
  import lzfg_pkg::*;
(
  input  logic              clk,
  input  hist_req_t         req,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem_r [HIST_DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  // Write on request, hold read data until the next read
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem_r[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/lzfg_seq.sv -----
// ----------------------------------------------------------------------------
// lzfg_seq
// Stream parser and copy sequencer: walks control bits, writes literals,
// and copies back references one byte per read/write pair into the lanes.
// ----------------------------------------------------------------------------
module lzfg_seq
  import lzfg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  lzfg_in_if.sink           in_ch,
  lzfg_out_if.source        out_ch,
  output hist_req_t         hist_req,
  input  logic [BYTE_W-1:0] hist_rdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_WRITE
  } state_t;

  typedef enum logic [1:0] {
    PH_CONTROL = 2'd0,
    PH_ITEM    = 2'd1,
    PH_LENGTH  = 2'd2
  } phase_t;

  state_t              state_r, state_nxt;
  phase_t              phase_r, phase_nxt;
  logic [BYTE_W-1:0]   flag_r, flag_nxt;
  logic [2:0]          item_r, item_nxt;
  logic [BYTE_W-1:0]   off_r, off_nxt;
  logic [HIST_AW-1:0]  wp_r, wp_nxt;
  logic [BYTE_W-1:0]   remain_r, remain_nxt;
  lanes_t              lane_r, lane_nxt;
  logic [LANE_IW-1:0]  lidx_r, lidx_nxt;
  logic                out_valid_r, out_valid_nxt;
  lanes_t              out_bytes_r, out_bytes_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic                out_last_r, out_last_nxt;
  status_t             out_status_r, out_status_nxt;

  logic   accept;
  logic   out_free;
  logic   emit;
  logic   trunc;
  lanes_t pack;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE) && out_free;
  assign accept       = in_ch.valid && in_ch.ready;
  assign trunc        = (phase_r == PH_LENGTH) || (phase_r == PH_ITEM && item_r == 3'd0);
  assign emit         = (lidx_r == LANE_IW'(LANES - 1)) || (remain_r == '0);

  // Merge the byte arriving from history into the staged lanes
  always_comb begin
    pack         = lane_r;
    pack[lidx_r] = hist_rdata;
  end

  // Next-state logic
  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    flag_nxt       = flag_r;
    item_nxt       = item_r;
    off_nxt        = off_r;
    wp_nxt         = wp_r;
    remain_nxt     = remain_r;
    lane_nxt       = lane_r;
    lidx_nxt       = lidx_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_bytes_nxt  = out_bytes_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    hist_req       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.operation == OP_END) begin
            // Report the end and rearm for a new stream
            out_valid_nxt  = 1'b1;
            out_bytes_nxt  = '0;
            out_count_nxt  = '0;
            out_last_nxt   = 1'b1;
            out_status_nxt = trunc ? ST_TRUNC : ST_END;
            phase_nxt      = PH_CONTROL;
            flag_nxt       = '0;
            item_nxt       = '0;
            off_nxt        = '0;
            wp_nxt         = '0;
          end else begin
            unique case (phase_r)
              PH_ITEM: begin
                if (flag_r[item_r]) begin
                  // Hold the offset until the length arrives
                  off_nxt   = in_ch.data_byte;
                  phase_nxt = PH_LENGTH;
                end else begin
                  // Literal: store and emit
                  hist_req.we    = 1'b1;
                  hist_req.waddr = wp_r;
                  hist_req.wdata = in_ch.data_byte;
                  wp_nxt         = wp_r + 1'b1;
                  out_valid_nxt  = 1'b1;
                  out_bytes_nxt  = '0;
                  out_bytes_nxt[0] = in_ch.data_byte;
                  out_count_nxt  = COUNT_W'(1);
                  out_last_nxt   = 1'b1;
                  out_status_nxt = ST_DATA;
                  item_nxt       = item_r + 1'b1;
                  phase_nxt      = (item_r == 3'd7) ? PH_CONTROL : PH_ITEM;
                end
              end
              PH_LENGTH: begin
                // Start the copy: remain counts bytes left after the current one
                remain_nxt = in_ch.data_byte;
                lane_nxt   = '0;
                lidx_nxt   = '0;
                state_nxt  = S_READ;
              end
              default: begin
                // Control byte (phase three behaves the same)
                flag_nxt  = in_ch.data_byte;
                item_nxt  = '0;
                phase_nxt = PH_ITEM;
              end
            endcase
          end
        end
      end

      S_READ: begin
        // Source is wp - (offset + 1), i.e. wp + ~offset
        hist_req.re    = 1'b1;
        hist_req.raddr = wp_r + ~off_r;
        state_nxt      = S_WRITE;
      end

      S_WRITE: begin
        // Stall only when a result must go out and the output is still held
        if (!emit || out_free) begin
          hist_req.we    = 1'b1;
          hist_req.waddr = wp_r;
          hist_req.wdata = hist_rdata;
          wp_nxt         = wp_r + 1'b1;
          if (emit) begin
            out_valid_nxt  = 1'b1;
            out_bytes_nxt  = pack;
            out_count_nxt  = COUNT_W'(lidx_r) + COUNT_W'(1);
            out_last_nxt   = (remain_r == '0);
            out_status_nxt = ST_DATA;
            lane_nxt       = '0;
            lidx_nxt       = '0;
          end else begin
            lane_nxt = pack;
            lidx_nxt = lidx_r + 1'b1;
          end
          if (remain_r == '0) begin
            item_nxt  = item_r + 1'b1;
            phase_nxt = (item_r == 3'd7) ? PH_CONTROL : PH_ITEM;
            state_nxt = S_IDLE;
          end else begin
            remain_nxt = remain_r - 1'b1;
            state_nxt  = S_READ;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_CONTROL;
      flag_r      <= '0;
      item_r      <= '0;
      wp_r        <= '0;
      lidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      flag_r      <= flag_nxt;
      item_r      <= item_nxt;
      wp_r        <= wp_nxt;
      lidx_r      <= lidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    off_r        <= off_nxt;
    remain_r     <= remain_nxt;
    lane_r       <= lane_nxt;
    out_bytes_r  <= out_bytes_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte0   = out_bytes_r[0];
  assign out_ch.out_byte1   = out_bytes_r[1];
  assign out_ch.out_byte2   = out_bytes_r[2];
  assign out_ch.out_byte3   = out_bytes_r[3];
  assign out_ch.out_count   = out_count_r;
  assign out_ch.last_of_run = out_last_r;
  assign out_ch.status      = out_status_r;

endmodule

// ----- test/lzss_flag_group_decoder_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_flag_group_decoder_top_test
// Self-checking bench for the LZSS flag-group decoder. Sends directed groups,
// then well-formed random groups with stray stream ends, under varied valid
// and ready idling. Every decoded result is predicted and compared in order.
// ----------------------------------------------------------------------------
module lzss_flag_group_decoder_top_test;
  import lzfg_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 5;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 250;
  localparam int DRAIN_TAIL     = 64;

  typedef enum logic [1:0] {
    EXPECT_CTRL = 2'd0,
    EXPECT_ITEM = 2'd1,
    EXPECT_LEN  = 2'd2
  } parse_t;

  typedef struct packed {
    lanes_t               lanes;
    logic [COUNT_W-1:0]   count;
    logic                 last;
    status_t              status;
  } dec_result_t;

  // Decoder state mirror and in-order store of predicted results
  class lzss_stream_model;
    parse_t         phase;
    logic [7:0]     flags;
    logic [2:0]     idx;
    logic [7:0]     offset;
    logic [7:0]     wpos;
    logic [7:0]     hist [HIST_DEPTH];
    bit             written [HIST_DEPTH];
    int             n_written;
    dec_result_t    pending_results [$];
    int             errors;
    int             n_in;
    int             n_out;
    int             n_ends;
    int             n_trunc;
    int             longest_copy;

    function new();
      rearm();
      foreach (hist[i]) begin
        hist[i]    = '0;
        written[i] = 1'b0;
      end
      n_written    = 0;
      errors       = 0;
      n_in         = 0;
      n_out        = 0;
      n_ends       = 0;
      n_trunc      = 0;
      longest_copy = 0;
    endfunction

    function void rearm();
      phase  = EXPECT_CTRL;
      flags  = '0;
      idx    = '0;
      offset = '0;
      wpos   = '0;
    endfunction

    function void put(logic [7:0] v);
      hist[wpos] = v;
      if (!written[wpos]) begin
        written[wpos] = 1'b1;
        n_written++;
      end
      wpos = wpos + 8'd1;
    endfunction

    // Advance to the next item of the group, or back to a control byte
    function void step_item();
      idx   = idx + 3'd1;
      phase = (idx == 3'd0) ? EXPECT_CTRL : EXPECT_ITEM;
    endfunction

    // True when every history read of this copy hits an entry already written
    function bit copy_readable(logic [7:0] off, logic [7:0] len);
      logic [7:0] back_dist;
      logic [7:0] src;
      int         k;
      back_dist = off + 8'd1;
      for (k = 0; k <= int'(len); k++) begin
        src = wpos + 8'(k) - back_dist;
        if (!written[src] && !(back_dist != 8'd0 && k >= int'(back_dist))) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Predict the results of one accepted input transaction
    function void note_input(op_t op, logic [7:0] b);
      dec_result_t r;
      logic [7:0]  back_dist;
      logic [7:0]  v;
      int          cnt;
      int          done;
      int          lane;
      bit          trunc;
      n_in++;
      r = '0;
      if (op == OP_END) begin
        trunc    = (phase == EXPECT_LEN) || (phase == EXPECT_ITEM && idx == 3'd0);
        r.last   = 1'b1;
        r.status = trunc ? ST_TRUNC : ST_END;
        pending_results.push_back(r);
        n_ends++;
        if (trunc) n_trunc++;
        rearm();
      end else begin
        case (phase)
          EXPECT_ITEM: begin
            if (flags[idx]) begin
              offset = b;
              phase  = EXPECT_LEN;
            end else begin
              put(b);
              r.lanes[0] = b;
              r.count    = 3'd1;
              r.last     = 1'b1;
              r.status   = ST_DATA;
              pending_results.push_back(r);
              step_item();
            end
          end
          EXPECT_LEN: begin
            back_dist = offset + 8'd1;
            cnt       = int'(b) + 1;
            done      = 0;
            if (cnt > longest_copy) longest_copy = cnt;
            // Copy byte by byte, so overlapping references repeat fresh bytes
            while (done < cnt) begin
              r    = '0;
              lane = 0;
              while (lane < LANES && done < cnt) begin
                v = hist[wpos - back_dist];
                put(v);
                r.lanes[lane] = v;
                lane++;
                done++;
              end
              r.count  = COUNT_W'(lane);
              r.last   = (done == cnt);
              r.status = ST_DATA;
              pending_results.push_back(r);
            end
            step_item();
          end
          default: begin
            flags = b;
            idx   = '0;
            phase = EXPECT_ITEM;
          end
        endcase
      end
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(dec_result_t got);
      dec_result_t exp_r;
      int          i;
      n_out++;
      if (pending_results.size() == 0) begin
        $error("result with no prediction waiting: count %0d status %0d",
               got.count, got.status);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      for (i = 0; i < LANES; i++) begin
        if (got.lanes[i] !== exp_r.lanes[i]) begin
          $error("out_byte%0d expected %0d actual %0d", i, exp_r.lanes[i], got.lanes[i]);
          errors++;
        end
      end
      if (got.count !== exp_r.count) begin
        $error("out_count expected %0d actual %0d", exp_r.count, got.count);
        errors++;
      end
      if (got.last !== exp_r.last) begin
        $error("last_of_run expected %0d actual %0d", exp_r.last, got.last);
        errors++;
      end
      if (got.status !== exp_r.status) begin
        $error("status expected %0d actual %0d", exp_r.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  lzfg_in_if        in_ch();
  lzfg_out_if       out_ch();
  lzss_stream_model sb;
  int               in_idle_pct;
  int               out_idle_pct;
  bit               hold_req;
  int               quiet_cycles;
  logic [7:0]       planned_off;
  logic [7:0]       planned_len;
  dec_result_t      got;

  lzss_flag_group_decoder_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // Drive ready at the falling edge: random idling, or one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    hold_req     = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99, 0) >= out_idle_pct);
      end
    end
  end

  // Sample both channels at the rising edge; watch for a hung block
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_input(op_t'(in_ch.operation), in_ch.data_byte);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.lanes  = {out_ch.out_byte3, out_ch.out_byte2, out_ch.out_byte1, out_ch.out_byte0};
        got.count  = out_ch.out_count;
        got.last   = out_ch.last_of_run;
        got.status = status_t'(out_ch.status);
        sb.check_result(got);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
          $display("lzss_flag_group_decoder_top_test: errors");
          $finish;
        end
      end
    end
  end

  // Offer one input transaction, with random idle cycles ahead of it
  task automatic send_item(input op_t op, input logic [7:0] b);
    while ($urandom_range(99, 0) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Choose an offset and length whose reads hit only written history
  task automatic plan_reference();
    logic [7:0] off;
    logic [7:0] len;
    logic [7:0] src;
    int         tries;
    int         k;
    for (tries = 0; tries < 30; tries++) begin
      off = ($urandom_range(1, 0) == 0) ? 8'($urandom_range(15, 0)) : 8'($urandom);
      k   = $urandom_range(99, 0);
      if (k < 80)      len = 8'($urandom_range(15, 0));
      else if (k < 95) len = 8'($urandom_range(63, 16));
      else             len = 8'($urandom_range(255, 64));
      if (sb.copy_readable(off, len)) begin
        planned_off = off;
        planned_len = len;
        return;
      end
    end
    // Fall back to a one-byte copy of the nearest written entry
    planned_len = 8'd0;
    planned_off = 8'd0;
    for (k = 1; k <= HIST_DEPTH; k++) begin
      src = sb.wpos - 8'(k);
      if (sb.written[src]) begin
        planned_off = 8'(k - 1);
        break;
      end
    end
  endtask

  // Send the next byte of a well-formed stream, following the decoder's phase
  task automatic send_next_byte();
    logic [7:0] b;
    case (sb.phase)
      EXPECT_ITEM: begin
        if (sb.flags[sb.idx]) begin
          plan_reference();
          send_item(OP_DATA, planned_off);
        end else begin
          send_item(OP_DATA, 8'($urandom));
        end
      end
      EXPECT_LEN: send_item(OP_DATA, planned_len);
      default: begin
        // Before any history exists the first item must be a literal
        b = 8'($urandom);
        if (sb.n_written == 0) b[0] = 1'b0;
        send_item(OP_DATA, b);
      end
    endcase
  endtask

  // Mostly well-formed bytes; a few stream ends land anywhere
  task automatic run_random(input int n);
    repeat (n) begin
      if ($urandom_range(99, 0) < 5) send_item(OP_END, 8'($urandom));
      else send_next_byte();
    end
  endtask

  // Hold the input until every predicted result has come out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic run_directed();
    // End of an empty stream
    send_item(OP_END, 8'h00);
    // Group: literal 00, copy of one, literal FF, overlapping copy of six,
    // then four literals closing the group
    send_item(OP_DATA, 8'h0A);
    send_item(OP_DATA, 8'h00);
    send_item(OP_DATA, 8'h00); send_item(OP_DATA, 8'h00);
    send_item(OP_DATA, 8'hFF);
    send_item(OP_DATA, 8'h01); send_item(OP_DATA, 8'h05);
    send_item(OP_DATA, 8'hA5); send_item(OP_DATA, 8'h5A);
    send_item(OP_DATA, 8'h01); send_item(OP_DATA, 8'h80);
    // Truncated right after a control byte
    send_item(OP_DATA, 8'h01);
    send_item(OP_END, 8'hFF);
    // Truncated right after an offset byte
    send_item(OP_DATA, 8'h01);
    send_item(OP_DATA, 8'h00);
    send_item(OP_END, 8'h00);
    // Full-window distance, then the longest overlapping copy, then clean end
    send_item(OP_DATA, 8'h03);
    send_item(OP_DATA, 8'hFF); send_item(OP_DATA, 8'h00);
    send_item(OP_DATA, 8'h00); send_item(OP_DATA, 8'hFF);
    send_item(OP_END, 8'h00);
  endtask

  initial begin
    sb              = new();
    quiet_cycles    = 0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_DATA;
    in_ch.data_byte = 8'h00;
    in_idle_pct     = 30;
    out_idle_pct    = 64;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Sender idles less than the receiver
    run_directed();
    run_random(40);
    wait_drained();

    // Receiver idles less than the sender
    in_idle_pct  = 64;
    out_idle_pct = 30;
    run_random(30);
    wait_drained();

    // No idling; one long receiver hold-off fills the block
    in_idle_pct  = 0;
    out_idle_pct = 0;
    hold_req     = 1'b1;
    run_random(20);
    wait_drained();
    run_random(10);
    wait_drained();
    repeat (DRAIN_TAIL) @(negedge clk);

    $display("run: %0d compressed transactions decoded into %0d results",
             sb.n_in, sb.n_out);
    $display("run: %0d stream ends, %0d truncated, longest back reference %0d bytes",
             sb.n_ends, sb.n_trunc, sb.longest_copy);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("lzss_flag_group_decoder_top_test: clean");
    end else begin
      $display("lzss_flag_group_decoder_top_test: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/lzfg_pkg.sv
rtl/core/lzfg_in_if.sv
rtl/core/lzfg_out_if.sv
rtl/core/lzfg_history.sv
rtl/core/lzfg_seq.sv
rtl/core/lzfg_top.sv
test/lzss_flag_group_decoder_top_test.sv
